FILE: sv/rns_pkg.sv
// ----------------------------------------------------------------------------
// rns_pkg
// Shared widths for the row norm and L2,1 norm block.
// ----------------------------------------------------------------------------
package rns_pkg;

    localparam int ELEM_W = 24;   // signed Q8.16 element
    localparam int SQ_W   = 2 * ELEM_W;
    localparam int SUM_W  = 64;   // Q.32 row sum of squares
    localparam int ROOT_W = SUM_W / 2;
    localparam int NORM_W = 48;   // Q.16 norms
    localparam int CNT_W  = $clog2(ROOT_W);

    typedef logic [ELEM_W-1:0] elem_t;
    typedef logic [NORM_W-1:0] norm_t;

endpackage

FILE: sv/row_norm_sum_top.sv
// ----------------------------------------------------------------------------
// row_norm_sum_top
// Streaming row Euclidean norm and L2,1 matrix norm with saturation.
// ----------------------------------------------------------------------------
// Elements arrive in row-major order. An element that closes neither a row
// nor the matrix passes through accept, square and accumulate steps. An
// element that closes a row then goes on to the square root, found one result
// bit per cycle by a single shared compare-and-subtract unit, then to the
// saturating total, and then delivers its results. A matrix end adds the total
// as a second item. The block holds in_stall high while it works and while a
// result waits.
module row_norm_sum_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rns_pkg::elem_t       element,
    input  logic                 row_end,
    input  logic                 matrix_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rns_pkg::norm_t       norm_value,
    output logic                 norm_kind,
    output logic                 last,
    output logic                 saturated
);

    import rns_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SQUARE  = 3'd1;
    localparam logic [2:0] S_ACCUM   = 3'd2;
    localparam logic [2:0] S_ROOT    = 3'd3;
    localparam logic [2:0] S_TOTAL   = 3'd4;
    localparam logic [2:0] S_ROW_OUT = 3'd5;
    localparam logic [2:0] S_TOT_OUT = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [SUM_W-1:0]  row_sum_reg, row_sum_next;
    logic [NORM_W-1:0] total_reg, total_next;
    logic              flag_reg, flag_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    elem_t             elem_reg, elem_next;
    logic              row_end_reg, row_end_next;
    logic              mat_end_reg, mat_end_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [SUM_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    norm_t             value_reg, value_next;
    logic              kind_reg, kind_next;
    logic              last_reg, last_next;
    logic              sat_reg, sat_next;

    logic [ELEM_W-1:0] mag;
    logic [SUM_W:0]    sum_ext;
    logic [NORM_W:0]   tot_ext;
    logic [ROOT_W+3:0] rem_try;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] rem_diff;
    logic              fits;

    assign mag     = elem_reg[ELEM_W-1] ? (~elem_reg + 1'b1) : elem_reg;
    assign sum_ext = {1'b0, row_sum_reg} + {{(SUM_W-SQ_W+1){1'b0}}, sq_reg};
    assign tot_ext = {1'b0, total_reg} + {{(NORM_W-ROOT_W+1){1'b0}}, root_reg};

    // One step of the digit-by-digit square root: bring down two radicand
    // bits and try to subtract 4*root+1.
    assign rem_try  = {rem_reg, rad_reg[SUM_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign rem_diff = rem_try - trial;
    assign fits     = (rem_try >= trial);

    always_comb
    begin
        state_next   = state_reg;
        row_sum_next = row_sum_reg;
        total_next   = total_reg;
        flag_next    = flag_reg;
        cnt_next     = cnt_reg;
        elem_next    = elem_reg;
        row_end_next = row_end_reg;
        mat_end_next = mat_end_reg;
        sq_next      = sq_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        value_next   = value_reg;
        kind_next    = kind_reg;
        last_next    = last_reg;
        sat_next     = sat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    elem_next    = element;
                    row_end_next = row_end;
                    mat_end_next = matrix_end;
                    state_next   = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                sq_next    = mag * mag;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                if (sum_ext[SUM_W])
                begin
                    row_sum_next = '1;
                    flag_next    = 1'b1;
                end
                else
                begin
                    row_sum_next = sum_ext[SUM_W-1:0];
                end
                if (row_end_reg || mat_end_reg)
                begin
                    rad_next   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROOT:
            begin
                rad_next  = {rad_reg[SUM_W-3:0], 2'b00};
                rem_next  = fits ? rem_diff[ROOT_W+1:0] : rem_try[ROOT_W+1:0];
                root_next = {root_reg[ROOT_W-2:0], fits};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    state_next = S_TOTAL;
                end
            end
            S_TOTAL:
            begin
                row_sum_next = '0;
                if (tot_ext[NORM_W])
                begin
                    total_next = '1;
                    flag_next  = 1'b1;
                    sat_next   = 1'b1;
                end
                else
                begin
                    total_next = tot_ext[NORM_W-1:0];
                    sat_next   = flag_reg;
                end
                value_next = {{(NORM_W-ROOT_W){1'b0}}, root_reg};
                kind_next  = 1'b0;
                last_next  = 1'b0;
                state_next = S_ROW_OUT;
            end
            S_ROW_OUT:
            begin
                if (!out_stall)
                begin
                    if (mat_end_reg)
                    begin
                        value_next = total_reg;
                        kind_next  = 1'b1;
                        last_next  = 1'b1;
                        sat_next   = flag_reg;
                        state_next = S_TOT_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_TOT_OUT:
            begin
                if (!out_stall)
                begin
                    total_next = '0;
                    flag_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            row_sum_reg <= '0;
            total_reg   <= '0;
            flag_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_sum_reg <= row_sum_next;
            total_reg   <= total_next;
            flag_reg    <= flag_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg    <= elem_next;
        row_end_reg <= row_end_next;
        mat_end_reg <= mat_end_next;
        sq_reg      <= sq_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        value_reg   <= value_next;
        kind_reg    <= kind_next;
        last_reg    <= last_next;
        sat_reg     <= sat_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_ROW_OUT) || (state_reg == S_TOT_OUT);
    assign norm_value = value_reg;
    assign norm_kind  = kind_reg;
    assign last       = last_reg;
    assign saturated  = sat_reg;

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for row_norm_sum_top. A short table of directed items
// (element extremes, both end marks, a matrix closed by its end mark alone)
// is followed by random matrices and stray items, scored against typed results
// or an in-bench model of the row and L2,1 norms. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rns_pkg::*;

    localparam logic KIND_ROW   = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    localparam int RANDOM_ITEMS = 550;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int IDLE_PCT     = 36;

    typedef struct packed {
        elem_t       element;
        logic        row_end;
        logic        matrix_end;
        logic [31:0] reps;
        logic        typed;
        norm_t       row_want;
        norm_t       total;
        logic        sat;
    } stim_row_t;

    typedef struct packed {
        norm_t value;
        logic  kind;
        logic  last;
        logic  sat;
    } norm_res_t;

    localparam int PLAN_LEN = 19;

    // Fields: element, row_end, matrix_end, repeat count, typed, row norm,
    // total, saturated. Rows without a typed result go to the model.
    localparam stim_row_t PLAN [0:PLAN_LEN-1] = '{
        '{24'h000000, 1'b1, 1'b0, 32'd1, 1'b1, 48'd0,          48'd0,          1'b0},
        '{24'h010000, 1'b1, 1'b0, 32'd1, 1'b1, 48'd65536,      48'd0,          1'b0},
        '{24'h800000, 1'b1, 1'b0, 32'd1, 1'b1, 48'd8388608,    48'd0,          1'b0},
        '{24'h7FFFFF, 1'b1, 1'b0, 32'd1, 1'b1, 48'd8388607,    48'd0,          1'b0},
        '{24'hFFFFFF, 1'b1, 1'b0, 32'd1, 1'b1, 48'd1,          48'd0,          1'b0},
        '{24'h000001, 1'b1, 1'b0, 32'd1, 1'b1, 48'd1,          48'd0,          1'b0},
        '{24'h000000, 1'b0, 1'b1, 32'd1, 1'b1, 48'd0,          48'd16842753,   1'b0},
        '{24'h030000, 1'b0, 1'b0, 32'd1, 1'b0, 48'd0,          48'd0,          1'b0},
        '{24'h040000, 1'b1, 1'b1, 32'd1, 1'b1, 48'd327680,     48'd327680,     1'b0},
        '{24'hFD0000, 1'b0, 1'b0, 32'd1, 1'b0, 48'd0,          48'd0,          1'b0},
        '{24'hFC0000, 1'b1, 1'b0, 32'd1, 1'b1, 48'd327680,     48'd0,          1'b0},
        '{24'h000005, 1'b0, 1'b0, 32'd1, 1'b0, 48'd0,          48'd0,          1'b0},
        '{24'h00000C, 1'b1, 1'b0, 32'd1, 1'b1, 48'd13,         48'd0,          1'b0},
        '{24'h000000, 1'b0, 1'b1, 32'd1, 1'b1, 48'd0,          48'd327693,     1'b0},
        '{24'h000002, 1'b0, 1'b0, 32'd1, 1'b0, 48'd0,          48'd0,          1'b0},
        '{24'h000002, 1'b1, 1'b0, 32'd1, 1'b0, 48'd0,          48'd0,          1'b0},
        '{24'h000005, 1'b0, 1'b0, 32'd1, 1'b0, 48'd0,          48'd0,          1'b0},
        '{24'h000005, 1'b0, 1'b1, 32'd1, 1'b0, 48'd0,          48'd0,          1'b0},
        '{24'h7FFFFF, 1'b1, 1'b1, 32'd1, 1'b1, 48'd8388607,    48'd8388607,    1'b0}
    };

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    elem_t element;
    logic  row_end;
    logic  matrix_end;
    logic  out_valid;
    logic  out_stall;
    norm_t norm_value;
    logic  norm_kind;
    logic  last;
    logic  saturated;

    // Model state: row sum of squares (Q.32), running norm total (Q.16), flag.
    logic [SUM_W-1:0]  acc_sq;
    logic [NORM_W-1:0] acc_norm;
    logic              acc_ovf;

    norm_res_t pending_norms [$];

    int  errors;
    int  items_sent;
    int  rows_checked;
    int  totals_checked;
    int  cycle_count;
    bit  calm;
    bit  hold_req;
    bit  hold_done;

    row_norm_sum_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .element    (element),
        .row_end    (row_end),
        .matrix_end (matrix_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .norm_value (norm_value),
        .norm_kind  (norm_kind),
        .last       (last),
        .saturated  (saturated)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] trial;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = r | (32'd1 << b);
            if ({32'b0, trial} * {32'b0, trial} <= v)
                r = trial;
        end
        return r;
    endfunction

    // Folds one element into the norm state and returns how many results it
    // closes (0, 1 or 2).
    function automatic int advance_norms(input elem_t e, input logic re, input logic me,
                                         output norm_res_t row_res,
                                         output norm_res_t total_res);
        logic [ELEM_W-1:0]   mag;
        logic [2*ELEM_W-1:0] sq;
        logic [SUM_W:0]      sum_wide;
        logic [31:0]         root;
        logic [NORM_W:0]     total_wide;
        row_res   = '0;
        total_res = '0;
        mag = e[ELEM_W-1] ? (~e + 1'b1) : e;
        sq  = mag * mag;
        sum_wide = {1'b0, acc_sq} + {{(SUM_W + 1 - 2 * ELEM_W){1'b0}}, sq};
        if (sum_wide[SUM_W])
        begin
            acc_sq  = '1;
            acc_ovf = 1'b1;
        end
        else
            acc_sq = sum_wide[SUM_W-1:0];
        if (!re && !me)
            return 0;
        root = floor_root(acc_sq);
        total_wide = {1'b0, acc_norm} + {{(NORM_W - 31){1'b0}}, root};
        if (total_wide[NORM_W])
        begin
            acc_norm = '1;
            acc_ovf  = 1'b1;
        end
        else
            acc_norm = total_wide[NORM_W-1:0];
        acc_sq = '0;
        row_res = '{value: {{(NORM_W - 32){1'b0}}, root}, kind: KIND_ROW,
                    last: 1'b0, sat: acc_ovf};
        if (!me)
            return 1;
        total_res = '{value: acc_norm, kind: KIND_TOTAL, last: 1'b1, sat: acc_ovf};
        acc_norm = '0;
        acc_ovf  = 1'b0;
        return 2;
    endfunction

    function automatic elem_t pick_element();
        elem_t e;
        case ($urandom_range(5))
            3: begin
                e = elem_t'($urandom_range(511));
                if ($urandom_range(1))
                    e = ~e + 1'b1;
            end
            4: e = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
            5: e = {8'($urandom_range(255)), 16'h0000};
            default: e = elem_t'($urandom);
        endcase
        return e;
    endfunction

    function automatic stim_row_t plain_item(input elem_t e, input logic re, input logic me);
        stim_row_t it;
        it = '0;
        it.element    = e;
        it.row_end    = re;
        it.matrix_end = me;
        it.reps       = 32'd1;
        return it;
    endfunction

    // Called and returns just after a falling edge.
    task automatic send_item(input stim_row_t it);
        norm_res_t row_res;
        norm_res_t total_res;
        int        n;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        element    <= it.element;
        row_end    <= it.row_end;
        matrix_end <= it.matrix_end;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        n = advance_norms(it.element, it.row_end, it.matrix_end, row_res, total_res);
        if (it.typed)
        begin
            row_res.value   = it.row_want;
            row_res.sat     = it.sat;
            total_res.value = it.total;
            total_res.sat   = it.sat;
        end
        if (n > 0)
            pending_norms.push_back(row_res);
        if (n > 1)
            pending_norms.push_back(total_res);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic check_result();
        norm_res_t want;
        if (pending_norms.size() == 0)
        begin
            $error("unexpected result: norm_value %0d, norm_kind %0d", norm_value, norm_kind);
            errors++;
            return;
        end
        want = pending_norms.pop_front();
        if (want.kind == KIND_TOTAL)
            totals_checked++;
        else
            rows_checked++;
        if (norm_value !== want.value)
        begin
            $error("norm_value: expected %0d, got %0d", want.value, norm_value);
            errors++;
        end
        if (norm_kind !== want.kind)
        begin
            $error("norm_kind: expected %0d, got %0d", want.kind, norm_kind);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
        end
        if (saturated !== want.sat)
        begin
            $error("saturated: expected %0d, got %0d", want.sat, saturated);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            check_result();
    end

    // Result side: random stalls, plus one long hold-off so the block backs up
    // into its input.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                out_stall <= 1'b0;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int   random_items;
        int   matrices;
        int   rows;
        int   cols;
        logic last_col;
        logic last_elem;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        element    = '0;
        row_end    = 1'b0;
        matrix_end = 1'b0;
        acc_sq     = '0;
        acc_norm   = '0;
        acc_ovf    = 1'b0;
        errors     = 0;
        items_sent = 0;
        rows_checked   = 0;
        totals_checked = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        random_items = 0;
        matrices     = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            // Repeated rows run without gaps on either side.
            calm = (PLAN[i].reps > 1);
            for (int k = 0; k < PLAN[i].reps; k++)
                send_item(PLAN[i]);
        end
        calm = 1'b0;

        // Neither accumulator can saturate within a run of this length. A
        // stretch in the middle of the random part runs with no idling.
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items > 120)
                hold_req = 1'b1;
            calm = (random_items >= 300 && random_items < 380);
            if ($urandom_range(99) < 20)
            begin
                send_item(plain_item(pick_element(), $urandom_range(1),
                                     $urandom_range(5) == 0));
                random_items++;
            end
            else
            begin
                matrices++;
                calm = calm || (matrices % 8 == 3);
                rows = $urandom_range(1, 5);
                cols = ($urandom_range(15) == 0) ? $urandom_range(20, 48)
                                                 : $urandom_range(1, 8);
                for (int r = 0; r < rows; r++)
                begin
                    for (int c = 0; c < cols; c++)
                    begin
                        last_col  = (c == cols - 1);
                        last_elem = last_col && (r == rows - 1);
                        // Sometimes the matrix end closes the row on its own.
                        send_item(plain_item(pick_element(),
                                             last_col && !(last_elem && $urandom_range(3) == 0),
                                             last_elem));
                        random_items++;
                    end
                end
            end
            calm = 1'b0;
        end
        in_valid <= 1'b0;

        while (pending_norms.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d items driven, %0d random over %0d matrices plus stray marks",
                 items_sent, random_items, matrices);
        $display("tb: %0d row norms and %0d totals checked, %0d errors",
                 rows_checked, totals_checked, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
